// ===== rtl/core/rbii_pkg.sv =====
// shared types, constants and state codes of the breakpoint index interpolator
package rbii_pkg;

   localparam int DEF_TABLE_ENTRIES = 16;
   localparam int MAX_TABLE_ENTRIES = 16;
   localparam int ENTRY_W           = 4;
   localparam int THR_W             = 16;
   localparam int BYTE_W            = 8;
   localparam int CTL_SHIFT_BIT     = 7;
   localparam int CTL_HIGH_BIT      = 6;

   typedef enum logic {
      FUNC_WRITE  = 1'b0,
      FUNC_LOOKUP = 1'b1
   } func_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_MULT
   } state_type;

   typedef struct packed {
      logic [THR_W-1:0]  threshold;
      logic [BYTE_W-1:0] control;
      logic [BYTE_W-1:0] factor;
   } entry_type;

   typedef struct packed {
      logic               en;
      logic [ENTRY_W-1:0] addr;
      entry_type          data;
   } wr_port_type;

endpackage

// ===== rtl/core/rbii_if.sv =====
// request and response channel interfaces
interface rbii_req_if
   import rbii_pkg::*;
   ();
   logic               valid;
   logic               ready;
   logic               func;
   logic [ENTRY_W-1:0] entry_index;
   logic [THR_W-1:0]   threshold;
   logic [BYTE_W-1:0]  control;
   logic [BYTE_W-1:0]  factor;
   logic [THR_W-1:0]   period;

   modport source (output valid, func, entry_index, threshold, control, factor, period,
                   input ready);
   modport sink (input valid, func, entry_index, threshold, control, factor, period,
                 output ready);
endinterface

interface rbii_rsp_if
   import rbii_pkg::*;
   ();
   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] map_index;
   logic [BYTE_W-1:0] bracket;
   logic              in_range;

   modport source (output valid, map_index, bracket, in_range, input ready);
   modport sink (input valid, map_index, bracket, in_range, output ready);
endinterface

// ===== rtl/core/rbii_table.sv =====
// breakpoint table memory, one write port and one registered read port
module rbii_table
   import rbii_pkg::*;
#(
   parameter int TABLE_ENTRIES = DEF_TABLE_ENTRIES,
   localparam int AW = $clog2(TABLE_ENTRIES)
) (
   input  logic        clock,
   input  wr_port_type wr,
   input  logic [AW-1:0] rd_addr,
   output entry_type   rd_data
);

   localparam logic [ENTRY_W:0] DEPTH = (ENTRY_W+1)'(TABLE_ENTRIES);

   entry_type mem [TABLE_ENTRIES];
   entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr.en && ({1'b0, wr.addr} < DEPTH)) begin
         mem[wr.addr[AW-1:0]] <= wr.data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/core/rpm_breakpoint_index_interpolator_top.sv =====
// top level of the breakpoint index interpolator
//
//   channel  direction  transfer moves
//   req_chan in         one table write or one period lookup
//   rsp_chan out        map_index, bracket, in_range of one lookup
//
// a write is taken in ST_IDLE; a lookup scans the table memory serially from entry 0 until
// a threshold reaches the period or the last entry is read, then forms the result in ST_MULT
// synchronous reset clears control state only; table contents are undefined until written
// the result sits in an output register; the next request is taken while it waits,
// and a lookup finishing into a still-full output register holds until it drains
module rpm_breakpoint_index_interpolator_top
   import rbii_pkg::*;
#(
   parameter int TABLE_ENTRIES = DEF_TABLE_ENTRIES
) (
   input logic        clock,
   input logic        reset,
   rbii_req_if.sink   req_chan,
   rbii_rsp_if.source rsp_chan
);

   localparam int AW = $clog2(TABLE_ENTRIES);
   localparam logic [AW-1:0] LAST_ENTRY = AW'(TABLE_ENTRIES - 1);
   localparam logic [3:0]    LAST_BRK   = 4'(TABLE_ENTRIES - 1);

   state_type         state_ff, state_in;
   logic [AW-1:0]     scan_ff, scan_in;
   logic [THR_W-1:0]  period_ff, period_in;
   logic [BYTE_W-1:0] delta_ff, delta_in;
   logic [BYTE_W-1:0] fac_ff, fac_in;
   logic [3:0]        brk_ff, brk_in;
   logic              hit_ff, hit_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [BYTE_W-1:0] rsp_index_ff, rsp_index_in;
   logic [BYTE_W-1:0] rsp_brk_ff, rsp_brk_in;
   logic              rsp_range_ff, rsp_range_in;

   wr_port_type       wr;
   logic [AW-1:0]     rd_addr;
   entry_type         rd_data;
   logic [THR_W-1:0]  rem;
   logic [2*BYTE_W-1:0] prod;
   logic              out_free;
   logic              req_xfer;

   rbii_table #(.TABLE_ENTRIES(TABLE_ENTRIES)) u_table (
      .clock   (clock),
      .wr      (wr),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign req_xfer = req_chan.valid && req_chan.ready;
   assign out_free = !rsp_valid_ff || rsp_chan.ready;
   assign rem      = rd_data.threshold - period_ff;
   assign prod     = delta_ff * fac_ff;

   always_comb begin
      wr.en             = req_xfer && (func_type'(req_chan.func) == FUNC_WRITE);
      wr.addr           = req_chan.entry_index;
      wr.data.threshold = req_chan.threshold;
      wr.data.control   = req_chan.control;
      wr.data.factor    = req_chan.factor;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      scan_ff      <= scan_in;
      period_ff    <= period_in;
      delta_ff     <= delta_in;
      fac_ff       <= fac_in;
      brk_ff       <= brk_in;
      hit_ff       <= hit_in;
      rsp_index_ff <= rsp_index_in;
      rsp_brk_ff   <= rsp_brk_in;
      rsp_range_ff <= rsp_range_in;
   end

   always_comb begin
      state_in     = state_ff;
      scan_in      = scan_ff;
      period_in    = period_ff;
      delta_in     = delta_ff;
      fac_in       = fac_ff;
      brk_in       = brk_ff;
      hit_in       = hit_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      rsp_index_in = rsp_index_ff;
      rsp_brk_in   = rsp_brk_ff;
      rsp_range_in = rsp_range_ff;
      req_chan.ready = 1'b0;
      rd_addr      = '0;

      case (state_ff)
         ST_IDLE: begin
            req_chan.ready = 1'b1;
            if (req_chan.valid && (func_type'(req_chan.func) == FUNC_LOOKUP)) begin
               period_in = req_chan.period;
               scan_in   = '0;
               state_in  = ST_SCAN;
            end
         end
         ST_SCAN: begin
            rd_addr = scan_ff + AW'(1);
            if (rd_data.threshold >= period_ff) begin
               if (rd_data.control[CTL_SHIFT_BIT]) begin
                  delta_in = rem[11:4];
               end else if (rd_data.control[CTL_HIGH_BIT]) begin
                  delta_in = rem[15:8];
               end else begin
                  delta_in = rem[7:0];
               end
               fac_in   = rd_data.factor;
               brk_in   = LAST_BRK - 4'(scan_ff);
               hit_in   = 1'b1;
               state_in = ST_MULT;
            end else if (scan_ff == LAST_ENTRY) begin
               delta_in = '0;
               fac_in   = '0;
               brk_in   = '0;
               hit_in   = 1'b0;
               state_in = ST_MULT;
            end else begin
               scan_in = scan_ff + AW'(1);
            end
         end
         ST_MULT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_index_in = prod[2*BYTE_W-1:BYTE_W] | {brk_ff, 4'b0000};
               rsp_brk_in   = {brk_ff, 4'b0000};
               rsp_range_in = hit_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_chan.valid     = rsp_valid_ff;
   assign rsp_chan.map_index = rsp_index_ff;
   assign rsp_chan.bracket   = rsp_brk_ff;
   assign rsp_chan.in_range  = rsp_range_ff;

endmodule
